// ----- rtl/fgc_pkg.sv -----
// ----------------------------------------------------------------------------
// Flex glove gesture classifier package
// Shared constants, request codes and controller/datapath command types.
// ----------------------------------------------------------------------------
package fgc_pkg;

  localparam int SENSOR_BITS_DEF    = 12;
  localparam int TEMPLATE_COUNT_DEF = 10;
  localparam int FINGERS            = 5;
  localparam int TOL_W              = 12;
  localparam int PCT_W              = 9;
  localparam int SLOT_IN_W          = 4;
  localparam int PITCH_W            = 9;
  localparam int MATCH_W            = 4;
  localparam int SUM_W              = 12;

  localparam logic [TOL_W-1:0] TOL_RESET = 12'd50;
  localparam int PCT_SCALE   = 100;
  localparam int PCT_MAX     = 255;
  // 13108 / 65536 approximates 1/5 exactly for magnitudes up to 1275.
  localparam logic [16:0] AVG_RECIP = 17'd13108;
  localparam int CLOSED_TH   = 8;
  localparam int HIGH_TH     = 85;
  localparam int LOW_TH      = 20;
  localparam int PITCH_TH    = 70;

  typedef enum logic [1:0] {
    REQ_CLASSIFY = 2'd0,
    REQ_OPEN     = 2'd1,
    REQ_CLOSED   = 2'd2,
    REQ_TEMPLATE = 2'd3
  } req_t;

  typedef struct packed {
    logic       capture;
    logic       div_start;
    logic       pct_store;
    logic       scan_step;
    logic       avg;
    logic       load_out;
    logic [2:0] finger;
  } fgc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic scan_last;
    logic out_full;
  } fgc_sts_t;

endpackage

// ----- rtl/fgc_if.sv -----
// ----------------------------------------------------------------------------
// Flex glove gesture classifier channels
// Valid/ready interfaces for the sensor frame and the classification result.
// ----------------------------------------------------------------------------
interface fgc_in_if #(parameter int SB = 12);
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [3:0]           template_slot;
  logic [SB-1:0]        thumb_bend;
  logic [SB-1:0]        index_bend;
  logic [SB-1:0]        middle_bend;
  logic [SB-1:0]        ring_bend;
  logic [SB-1:0]        pinky_bend;
  logic signed [8:0]    pitch_angle;

  modport source (output valid, req_type, template_slot, thumb_bend, index_bend,
                  middle_bend, ring_bend, pinky_bend, pitch_angle, input ready);
  modport sink (input valid, req_type, template_slot, thumb_bend, index_bend,
                middle_bend, ring_bend, pinky_bend, pitch_angle, output ready);
endinterface

interface fgc_out_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] thumb_pct;
  logic signed [8:0] index_pct;
  logic signed [8:0] middle_pct;
  logic signed [8:0] ring_pct;
  logic signed [8:0] pinky_pct;
  logic signed [8:0] overall_pct;
  logic              hand_closed;
  logic              horns_sign;
  logic              stop_sign;
  logic [3:0]        matched_gesture;
  logic              range_fault;

  modport source (output valid, thumb_pct, index_pct, middle_pct, ring_pct, pinky_pct,
                  overall_pct, hand_closed, horns_sign, stop_sign, matched_gesture,
                  range_fault, input ready);
  modport sink (input valid, thumb_pct, index_pct, middle_pct, ring_pct, pinky_pct,
                overall_pct, hand_closed, horns_sign, stop_sign, matched_gesture,
                range_fault, output ready);
endinterface

// ----- rtl/fgc_div.sv -----
// ----------------------------------------------------------------------------
// Serial divider
// Unsigned restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fgc_div #(
  parameter int NB = 20,
  parameter int DB = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NB-1:0] num,
  input  logic [DB-1:0] den,
  output logic          done,
  output logic [NB-1:0] quo
);

  localparam int CW = $clog2(NB + 1);

  logic [NB-1:0] quo_r, quo_nxt;
  logic [DB-1:0] rem_r, rem_nxt;
  logic [DB-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          act_r, done_r;
  logic [DB:0]   shifted;
  logic          qbit;

  always_comb begin
    shifted = {rem_r, quo_r[NB-1]};
    qbit    = (shifted >= {1'b0, den_r});
    rem_nxt = qbit ? DB'(shifted - {1'b0, den_r}) : shifted[DB-1:0];
    quo_nxt = {quo_r[NB-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        act_r <= 1'b1;
        cnt_r <= CW'(NB);
        quo_r <= num;
        rem_r <= '0;
        den_r <= den;
      end else if (act_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          act_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ----- rtl/fgc_datapath.sv -----
// ----------------------------------------------------------------------------
// Gesture classifier datapath
// Reference and template storage, percent division, template scan and result.
// ----------------------------------------------------------------------------
module fgc_datapath import fgc_pkg::*; #(
  parameter int SB = SENSOR_BITS_DEF,
  parameter int TC = TEMPLATE_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fgc_cmd_t              cmd,
  output fgc_sts_t              sts,
  input  logic                  cfg_we,
  input  logic [TOL_W-1:0]      cfg_wdata,
  input  logic [1:0]            in_req,
  input  logic [SLOT_IN_W-1:0]  in_slot,
  input  logic [SB-1:0]         in_bend [FINGERS],
  input  logic signed [PITCH_W-1:0] in_pitch,
  fgc_out_if.source             out_ch
);

  localparam int NB = SB + 8;
  localparam int DB = SB + 1;
  localparam int SW = (TC > 1) ? $clog2(TC) : 1;
  localparam int CMP_W = ((SB > TOL_W) ? SB : TOL_W) + 1;

  logic [TOL_W-1:0]   tol_r;
  logic [SB-1:0]      open_r   [FINGERS];
  logic [SB-1:0]      closed_r [FINGERS];
  logic [SB-1:0]      tpl_r    [TC][FINGERS];
  logic [TC-1:0]      tpl_vld_r;
  logic [SB-1:0]      bend_r   [FINGERS];
  logic signed [PITCH_W-1:0] pitch_r;
  logic signed [PCT_W-1:0]   pct_r [FINGERS];
  logic signed [SUM_W-1:0]   sum_r;
  logic signed [PCT_W-1:0]   ovr_r;
  logic               fault_r;
  logic [MATCH_W-1:0] match_r;
  logic [SW-1:0]      slot_r;
  logic               out_valid_r;

  // Percent of the selected finger.
  logic [SB-1:0]         sel_bend, sel_open, sel_closed;
  logic signed [SB:0]    diff_s, den_s;
  logic signed [NB-1:0]  num_s;
  logic [NB-1:0]         num_mag;
  logic [DB-1:0]         den_mag;
  logic                  neg, den_zero, div_done;
  logic [NB-1:0]         quo;
  logic [7:0]            sat;
  logic signed [PCT_W-1:0] pct_val;

  always_comb begin
    sel_bend   = bend_r[cmd.finger];
    sel_open   = open_r[cmd.finger];
    sel_closed = closed_r[cmd.finger];
    diff_s     = $signed({1'b0, sel_bend}) - $signed({1'b0, sel_open});
    den_s      = $signed({1'b0, sel_closed}) - $signed({1'b0, sel_open});
    num_s      = NB'(diff_s * PCT_SCALE);
    num_mag    = num_s[NB-1] ? NB'(-num_s) : NB'(num_s);
    den_mag    = den_s[SB] ? DB'(-den_s) : DB'(den_s);
    neg        = num_s[NB-1] ^ den_s[SB];
    den_zero   = (den_s == '0);
    sat        = (|quo[NB-1:8]) ? 8'(PCT_MAX) : quo[7:0];
    if (den_zero) begin
      pct_val = '0;
    end else if (neg) begin
      pct_val = -$signed({1'b0, sat});
    end else begin
      pct_val = $signed({1'b0, sat});
    end
  end

  fgc_div #(.NB(NB), .DB(DB)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_mag),
    .den   (den_mag),
    .done  (div_done),
    .quo   (quo)
  );

  // Template comparison for the slot under the scan pointer.
  logic tpl_ok;
  logic [SB-1:0] tdiff [FINGERS];

  always_comb begin
    tpl_ok = tpl_vld_r[slot_r];
    for (int f = 0; f < FINGERS; f++) begin
      tdiff[f] = (bend_r[f] >= tpl_r[slot_r][f]) ? SB'(bend_r[f] - tpl_r[slot_r][f])
                                                 : SB'(tpl_r[slot_r][f] - bend_r[f]);
      if (!(CMP_W'(tdiff[f]) < CMP_W'(tol_r))) tpl_ok = 1'b0;
    end
  end

  // Average by reciprocal multiplication.
  logic [SUM_W-2:0] sum_mag;
  logic [27:0]      avg_prod;
  logic signed [PCT_W-1:0] avg_q;

  always_comb begin
    sum_mag  = sum_r[SUM_W-1] ? (SUM_W-1)'(-sum_r) : sum_r[SUM_W-2:0];
    avg_prod = 28'(sum_mag * AVG_RECIP);
    avg_q    = $signed({1'b0, avg_prod[23:16]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r       <= TOL_RESET;
      tpl_vld_r   <= '0;
      out_valid_r <= 1'b0;
      for (int f = 0; f < FINGERS; f++) begin
        open_r[f]   <= '0;
        closed_r[f] <= '0;
      end
    end else begin
      if (cfg_we) tol_r <= cfg_wdata;

      if (cmd.capture) begin
        bend_r  <= in_bend;
        pitch_r <= in_pitch;
        sum_r   <= '0;
        fault_r <= 1'b0;
        match_r <= '0;
        slot_r  <= '0;
        case (req_t'(in_req))
          REQ_OPEN:     open_r   <= in_bend;
          REQ_CLOSED:   closed_r <= in_bend;
          REQ_TEMPLATE: begin
            if ({1'b0, in_slot} < 5'(TC)) begin
              tpl_r[in_slot[SW-1:0]]     <= in_bend;
              tpl_vld_r[in_slot[SW-1:0]] <= 1'b1;
            end
          end
          default: ;
        endcase
      end

      if (cmd.pct_store) begin
        pct_r[cmd.finger] <= pct_val;
        sum_r   <= sum_r + SUM_W'(pct_val);
        fault_r <= fault_r | den_zero;
      end

      if (cmd.scan_step) begin
        if (tpl_ok && match_r == '0) match_r <= MATCH_W'(slot_r + 1'b1);
        slot_r <= slot_r + 1'b1;
      end

      if (cmd.avg) ovr_r <= sum_r[SUM_W-1] ? -avg_q : avg_q;

      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register, loaded once the previous result has been taken.
  logic signed [PCT_W-1:0] o_pct_r [FINGERS];
  logic signed [PCT_W-1:0] o_ovr_r;
  logic o_closed_r, o_horns_r, o_stop_r, o_fault_r;
  logic [MATCH_W-1:0] o_match_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_pct_r    <= pct_r;
      o_ovr_r    <= ovr_r;
      o_closed_r <= (ovr_r > PCT_W'(CLOSED_TH));
      o_horns_r  <= (pct_r[0] > PCT_W'(HIGH_TH)) && (pct_r[1] < PCT_W'(LOW_TH)) &&
                    (pct_r[2] > PCT_W'(HIGH_TH)) && (pct_r[3] > PCT_W'(HIGH_TH)) &&
                    (pct_r[4] < PCT_W'(LOW_TH));
      o_stop_r   <= (ovr_r > PCT_W'(HIGH_TH)) && (pitch_r > PITCH_W'(PITCH_TH));
      o_match_r  <= match_r;
      o_fault_r  <= fault_r;
    end
  end

  assign sts.div_done  = div_done;
  assign sts.scan_last = (slot_r == SW'(TC - 1));
  assign sts.out_full  = out_valid_r;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.thumb_pct       = o_pct_r[0];
  assign out_ch.index_pct       = o_pct_r[1];
  assign out_ch.middle_pct      = o_pct_r[2];
  assign out_ch.ring_pct        = o_pct_r[3];
  assign out_ch.pinky_pct       = o_pct_r[4];
  assign out_ch.overall_pct     = o_ovr_r;
  assign out_ch.hand_closed     = o_closed_r;
  assign out_ch.horns_sign      = o_horns_r;
  assign out_ch.stop_sign       = o_stop_r;
  assign out_ch.matched_gesture = o_match_r;
  assign out_ch.range_fault     = o_fault_r;

endmodule

// ----- rtl/fgc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Gesture classifier controller
// Sequences capture, five divisions, the template scan, the average and the result load.
// ----------------------------------------------------------------------------
module fgc_ctrl import fgc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  fgc_sts_t sts,
  output fgc_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_START, ST_WAIT, ST_SCAN, ST_AVG, ST_OUT
  } state_t;

  state_t     state_r;
  logic [2:0] finger_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      finger_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          finger_r <= '0;
          if (in_valid) state_r <= ST_START;
        end
        ST_START: state_r <= ST_WAIT;
        ST_WAIT: begin
          if (sts.div_done) begin
            finger_r <= finger_r + 1'b1;
            state_r  <= (finger_r == 3'(FINGERS - 1)) ? ST_SCAN : ST_START;
          end
        end
        ST_SCAN: if (sts.scan_last) state_r <= ST_AVG;
        ST_AVG:  state_r <= ST_OUT;
        ST_OUT:  if (!sts.out_full) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    cmd.capture   = in_ready && in_valid;
    cmd.div_start = (state_r == ST_START);
    cmd.pct_store = (state_r == ST_WAIT) && sts.div_done;
    cmd.scan_step = (state_r == ST_SCAN);
    cmd.avg       = (state_r == ST_AVG);
    cmd.load_out  = (state_r == ST_OUT) && !sts.out_full;
    cmd.finger    = finger_r;
  end

endmodule

// ----- rtl/flex_glove_gesture_classifier.sv -----
// Each accepted frame passes capture, five divisions, the template scan, the average and
// the result load; the pace is set by the bit-serial divider shared by the five fingers.
// A new frame is taken only once the last one is done, and the result load waits for a
// free output register; a new frame is accepted while the last result still waits there.
// Reset (rst_n low, synchronous): references zero, templates invalid, tolerance 50.
// ----------------------------------------------------------------------------
// Flex glove gesture classifier
// Finger closure percents, hand gestures and template matching per sensor frame.
// ----------------------------------------------------------------------------
module flex_glove_gesture_classifier import fgc_pkg::*; #(
  parameter int SENSOR_BITS    = SENSOR_BITS_DEF,
  parameter int TEMPLATE_COUNT = TEMPLATE_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  fgc_in_if.sink           in_ch,
  fgc_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [TOL_W-1:0] cfg_wdata
);

  fgc_cmd_t          cmd;
  fgc_sts_t          sts;
  logic [SENSOR_BITS-1:0] bend [FINGERS];
  logic              rdy;

  assign bend[0] = in_ch.thumb_bend;
  assign bend[1] = in_ch.index_bend;
  assign bend[2] = in_ch.middle_bend;
  assign bend[3] = in_ch.ring_bend;
  assign bend[4] = in_ch.pinky_bend;
  assign in_ch.ready = rdy;

  fgc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (rdy),
    .sts      (sts),
    .cmd      (cmd)
  );

  fgc_datapath #(.SB(SENSOR_BITS), .TC(TEMPLATE_COUNT)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_ch.req_type),
    .in_slot   (in_ch.template_slot),
    .in_bend   (bend),
    .in_pitch  (in_ch.pitch_angle),
    .out_ch    (out_ch)
  );

endmodule

// ----- rtl/fgc_checker.sv -----
// ----------------------------------------------------------------------------
// Gesture classifier port checker
// Checks handshake ordering seen at the top-level ports.
// ----------------------------------------------------------------------------
module fgc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // A pending result is not dropped.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  // Frames are processed one at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second frame taken while busy");

  // No result is presented right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result valid after reset");

  // A taken result is never followed at once by another.
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid) else $error("result repeated");

endmodule

bind flex_glove_gesture_classifier fgc_checker u_fgc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);
